/* hdl/aqd_pkg.sv */
// Shared types, opcodes and constants for the affine quantize/dequantize block.
// No dependencies; used by the interfaces and the top level.
`default_nettype none
package aqd_pkg;

  localparam int WordW   = 32;
  localparam int OpW     = 3;
  localparam int ZeroW   = 17;
  localparam int CfgIdxW = 2;
  localparam int MantW   = 24;

  localparam logic [WordW-1:0] ScaleReset = 32'h3F80_0000;
  localparam logic [WordW-1:0] RecipReset = 32'h3F80_0000;
  localparam logic [WordW-1:0] CanonNan   = 32'h7FC0_0000;

  typedef enum logic [OpW-1:0] {
    OP_QUANT  = 3'd0,
    OP_DQ_U8  = 3'd1,
    OP_DQ_I8  = 3'd2,
    OP_DQ_U16 = 3'd3,
    OP_DQ_I16 = 3'd4
  } opcode_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SCALE = 2'd0,
    REG_RECIP = 2'd1,
    REG_ZERO  = 2'd2
  } cfg_reg_t;

  // Unpacked operand: value = mant * 2^(expo - 150).
  typedef struct packed {
    logic              sgn;
    logic signed [9:0] expo;
    logic [MantW-1:0]  mant;
    logic              nan;
    logic              inf;
    logic              zero;
  } operand_t;

  function automatic logic [4:0] lzc24(input logic [MantW-1:0] m);
    logic [4:0] n;
    n = 5'd0;
    for (int i = 0; i < MantW; i++) begin
      if (m[i]) begin
        n = 5'(MantW - 1 - i);
      end
    end
    return n;
  endfunction

  function automatic operand_t unpack_f32(input logic [WordW-1:0] b);
    operand_t o;
    o.sgn  = b[31];
    o.expo = (b[30:23] == 8'd0) ? 10'sd1 : $signed({2'b00, b[30:23]});
    o.mant = {b[30:23] != 8'd0, b[22:0]};
    o.nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    o.inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    o.zero = (b[30:0] == 31'd0);
    return o;
  endfunction

endpackage
`default_nettype wire

/* hdl/aqd_if.sv */
// Valid/ready channel interfaces for input items and result items.
// Depends on aqd_pkg.
`default_nettype none
interface aqd_in_if import aqd_pkg::*; (input wire logic clk);
  logic             valid;
  logic             ready;
  logic [OpW-1:0]   opcode;
  logic [WordW-1:0] value_word;
  logic             last_in;

  modport source (output valid, opcode, value_word, last_in, input ready);
  modport sink   (input valid, opcode, value_word, last_in, output ready);
endinterface

interface aqd_out_if import aqd_pkg::*; (input wire logic clk);
  logic             valid;
  logic             ready;
  logic [WordW-1:0] result_word;
  logic             last_out;

  modport source (output valid, result_word, last_out, input ready);
  modport sink   (input valid, result_word, last_out, output ready);
endinterface
`default_nettype wire

/* hdl/affine_quantize_dequantize_top.sv */
// Throughput one beat per cycle while dout.ready is high; dout.ready low stalls the full stages.
// Seven register stages: decode, normalise, 24x24 multiply, align, round,
// integer convert, zero-point add and clamp. Each stage holds its own valid
// bit and advances whenever the stage after it is free.
// Synchronous active-high reset clears valid bits and restores the registers
// (scale and reciprocal scale 1.0, zero point 0).
`default_nettype none
module affine_quantize_dequantize_top import aqd_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_wr_en,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [WordW-1:0]   cfg_wr_data,
  aqd_in_if.sink                  din,
  aqd_out_if.source               dout
);

  logic [WordW-1:0] scale_bits;
  logic [WordW-1:0] recip_bits;
  logic [ZeroW-1:0] zero_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_bits  <= ScaleReset;
      recip_bits  <= RecipReset;
      zero_offset <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_SCALE: scale_bits  <= cfg_wr_data;
        REG_RECIP: recip_bits  <= cfg_wr_data;
        REG_ZERO:  zero_offset <= cfg_wr_data[ZeroW-1:0];
        default: ;
      endcase
    end
  end

  logic [7:1] v;
  logic [7:1] adv;

  assign adv[7] = !v[7] || dout.ready;
  assign adv[6] = !v[6] || adv[7];
  assign adv[5] = !v[5] || adv[6];
  assign adv[4] = !v[4] || adv[5];
  assign adv[3] = !v[3] || adv[4];
  assign adv[2] = !v[2] || adv[3];
  assign adv[1] = !v[1] || adv[2];
  assign din.ready = adv[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[1]) v[1] <= din.valid;
      if (adv[2]) v[2] <= v[1];
      if (adv[3]) v[3] <= v[2];
      if (adv[4]) v[4] <= v[3];
      if (adv[5]) v[5] <= v[4];
      if (adv[6]) v[6] <= v[5];
      if (adv[7]) v[7] <= v[6];
    end
  end

  logic [OpW-1:0] op1, op2, op3, op4, op5, op6;
  logic           last1, last2, last3, last4, last5, last6;

  // Stage 1: decode, integer subtract, unpack
  logic signed [17:0] code_s;
  logic signed [17:0] diff_s;
  logic [16:0]        diff_mag;
  operand_t           opa_c, opb_c;
  logic               is_quant;

  assign is_quant = (din.opcode == OP_QUANT);

  always_comb begin
    unique case (din.opcode)
      OP_DQ_U8:  code_s = $signed({10'd0, din.value_word[7:0]});
      OP_DQ_I8:  code_s = $signed({{10{din.value_word[7]}}, din.value_word[7:0]});
      OP_DQ_U16: code_s = $signed({2'd0, din.value_word[15:0]});
      OP_DQ_I16: code_s = $signed({{2{din.value_word[15]}}, din.value_word[15:0]});
      default:   code_s = '0;
    endcase
    diff_s   = code_s - $signed({zero_offset[ZeroW-1], zero_offset});
    diff_mag = diff_s[17] ? 17'(-diff_s) : diff_s[16:0];
    if (is_quant) begin
      opa_c = unpack_f32(din.value_word);
      opb_c = unpack_f32(recip_bits);
    end else begin
      opa_c.sgn  = diff_s[17];
      opa_c.expo = 10'sd150;
      opa_c.mant = {7'd0, diff_mag};
      opa_c.nan  = 1'b0;
      opa_c.inf  = 1'b0;
      opa_c.zero = (diff_mag == 17'd0);
      opb_c = unpack_f32(scale_bits);
    end
  end

  operand_t opa1, opb1;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      op1   <= din.opcode;
      last1 <= din.last_in;
      opa1  <= opa_c;
      opb1  <= opb_c;
    end
  end

  // Stage 2: normalise both mantissas
  logic [4:0]        lza, lzb;
  logic [MantW-1:0]  ma2, mb2;
  logic signed [9:0] ea2, eb2;
  logic              sgn2, nan2, inf2, zero2;

  assign lza = lzc24(opa1.mant);
  assign lzb = lzc24(opb1.mant);

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      op2   <= op1;
      last2 <= last1;
      ma2   <= opa1.mant << lza;
      mb2   <= opb1.mant << lzb;
      ea2   <= opa1.expo - $signed({5'd0, lza});
      eb2   <= opb1.expo - $signed({5'd0, lzb});
      sgn2  <= opa1.sgn ^ opb1.sgn;
      nan2  <= opa1.nan || opb1.nan || (opa1.inf && opb1.zero) || (opa1.zero && opb1.inf);
      inf2  <= opa1.inf || opb1.inf;
      zero2 <= opa1.zero || opb1.zero;
    end
  end

  // Stage 3: mantissa product and exponent sum
  logic [47:0]        mp3;
  logic signed [10:0] es3;
  logic               sgn3, nan3, inf3, zero3;

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      op3   <= op2;
      last3 <= last2;
      mp3   <= ma2 * mb2;
      es3   <= 11'(ea2) + 11'(eb2);
      sgn3  <= sgn2;
      nan3  <= nan2;
      inf3  <= inf2;
      zero3 <= zero2;
    end
  end

  // Stage 4: align, denormalise with sticky
  logic [47:0]        nrm;
  logic signed [10:0] ex4;
  logic signed [10:0] shd;
  logic [4:0]         sh;
  logic [47:0]        shifted;
  logic               lost;
  logic [MantW-1:0]   m4;
  logic               g4, st4;
  logic signed [10:0] ef4;
  logic               sgn4, nan4, inf4, zero4;

  always_comb begin
    if (mp3[47]) begin
      nrm = mp3;
      ex4 = es3 - 11'sd126;
    end else begin
      nrm = mp3 << 1;
      ex4 = es3 - 11'sd127;
    end
    shd = 11'sd1 - ex4;
    if (ex4 >= 11'sd1) begin
      sh = 5'd0;
    end else if (shd > 11'sd26) begin
      sh = 5'd26;
    end else begin
      sh = shd[4:0];
    end
    shifted = nrm >> sh;
    lost    = (nrm & ((48'd1 << sh) - 48'd1)) != 48'd0;
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      op4   <= op3;
      last4 <= last3;
      m4    <= shifted[47:24];
      g4    <= shifted[23];
      st4   <= (|shifted[22:0]) || lost;
      ef4   <= (ex4 < 11'sd1) ? 11'sd1 : ex4;
      sgn4  <= sgn3;
      nan4  <= nan3;
      inf4  <= inf3;
      zero4 <= zero3;
    end
  end

  // Stage 5: round to nearest even, pack
  logic [MantW:0]     mr;
  logic [MantW-1:0]   mf;
  logic signed [10:0] ef5;
  logic [WordW-1:0]   bits_c;
  logic [WordW-1:0]   bits5;
  logic               nan5;

  always_comb begin
    mr = {1'b0, m4} + {{MantW{1'b0}}, g4 && (st4 || m4[0])};
    if (mr[MantW]) begin
      mf  = mr[MantW:1];
      ef5 = ef4 + 11'sd1;
    end else begin
      mf  = mr[MantW-1:0];
      ef5 = ef4;
    end
    priority if (nan4) begin
      bits_c = CanonNan;
    end else if (inf4 || ef5 >= 11'sd255) begin
      bits_c = {sgn4, 8'hFF, 23'd0};
    end else if (zero4) begin
      bits_c = {sgn4, 31'd0};
    end else begin
      bits_c = {sgn4, mf[23] ? ef5[7:0] : 8'd0, mf[22:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      op5   <= op4;
      last5 <= last4;
      bits5 <= bits_c;
      nan5  <= nan4;
    end
  end

  // Stage 6: round half away to integer magnitude
  logic [7:0]       e6;
  logic [MantW-1:0] x6;
  logic [MantW:0]   xr6;
  logic [MantW-1:0] mag_c;
  logic [MantW-1:0] mag6;
  logic             sgn6, nan6;
  logic [WordW-1:0] bits6;

  always_comb begin
    e6  = bits5[30:23];
    x6  = {1'b1, bits5[22:0]} >> (5'(8'd149 - e6));
    xr6 = ({1'b0, x6} + 25'd1) >> 1;
    if (e6 >= 8'd150) begin
      mag_c = {MantW{1'b1}};
    end else if (e6 < 8'd126) begin
      mag_c = '0;
    end else begin
      mag_c = xr6[MantW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      op6   <= op5;
      last6 <= last5;
      bits6 <= bits5;
      mag6  <= mag_c;
      sgn6  <= bits5[31];
      nan6  <= nan5;
    end
  end

  // Stage 7: add zero point, clamp, select result
  logic signed [25:0] t7, q7;
  logic [7:0]         q8;
  logic [WordW-1:0]   res_c;
  logic [WordW-1:0]   res7;
  logic               last7;

  always_comb begin
    t7 = sgn6 ? -$signed({2'b00, mag6}) : $signed({2'b00, mag6});
    q7 = t7 + 26'(signed'(zero_offset));
    priority if (nan6 || q7 > 26'sd255) begin
      q8 = 8'hFF;
    end else if (q7 < 26'sd0) begin
      q8 = 8'd0;
    end else begin
      q8 = q7[7:0];
    end
    unique case (op6)
      OP_QUANT: res_c = {24'd0, q8};
      OP_DQ_U8, OP_DQ_I8, OP_DQ_U16, OP_DQ_I16: res_c = bits6;
      default: res_c = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      res7  <= res_c;
      last7 <= last6;
    end
  end

  assign dout.valid       = v[7];
  assign dout.result_word = res7;
  assign dout.last_out    = last7;

endmodule
`default_nettype wire
